// ----- rtl/ipv4_cidr_text_parser_core_macros.svh -----
// ============================================================================
// ipv4_cidr_text_parser_core_macros.svh
// Assertion macros used by the parser core RTL.
// ============================================================================
`ifndef IPV4_CIDR_TEXT_PARSER_CORE_MACROS_SVH
`define IPV4_CIDR_TEXT_PARSER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ICP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ICP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/icp_pkg.sv -----
// ============================================================================
// icp_pkg
// Types and constants for the IPv4 dotted-quad / CIDR text parser.
// ============================================================================
package icp_pkg;

    localparam logic [2:0] PH_OCT0   = 3'd0;
    localparam logic [2:0] PH_OCT3   = 3'd3;
    localparam logic [2:0] PH_PREFIX = 3'd4;

    localparam logic [11:0] OCTET_MAX  = 12'd255;
    localparam logic [11:0] PREFIX_MAX = 12'd32;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [2:0]  phase;
        logic [7:0]  field_value;
        logic        digit_seen;
        logic [31:0] addr_acc;
        logic        failed;
    } icp_state_t;

    typedef struct packed {
        logic        valid_res;
        logic [31:0] address;
        logic        has_prefix;
        logic [5:0]  prefix_len;
    } icp_result_t;

    localparam icp_state_t STATE_RESET = '0;

endpackage

// ----- rtl/icp_step.sv -----
// ============================================================================
// icp_step
// Per-character next-state and end-of-string result logic.
// ============================================================================
module icp_step
(
    input  icp_pkg::icp_state_t  cur,
    input  logic [7:0]           ch,
    input  logic                 last,
    output icp_pkg::icp_state_t  nxt_state,
    output icp_pkg::icp_result_t res
);

    icp_pkg::icp_state_t nxt;
    logic                is_digit;
    logic [7:0]          digit_val;
    logic [11:0]         acc_sum;
    logic [11:0]         limit;

    assign is_digit  = (ch >= icp_pkg::CH_ZERO) && (ch <= icp_pkg::CH_NINE);
    assign digit_val = ch - icp_pkg::CH_ZERO;
    assign acc_sum   = 12'(cur.field_value) * 12'd10 + 12'(digit_val[3:0]);
    assign limit     = (cur.phase == icp_pkg::PH_PREFIX) ? icp_pkg::PREFIX_MAX
                                                         : icp_pkg::OCTET_MAX;

    always_comb
    begin
        nxt = cur;
        priority if (cur.failed || (cur.phase > icp_pkg::PH_PREFIX))
        begin
            nxt.failed = 1'b1;
        end
        else if (is_digit)
        begin
            if (acc_sum > limit)
            begin
                nxt.failed = 1'b1;
            end
            else
            begin
                nxt.field_value = acc_sum[7:0];
                nxt.digit_seen  = 1'b1;
            end
        end
        else if (ch == icp_pkg::CH_DOT)
        begin
            if ((cur.phase < icp_pkg::PH_OCT3) && cur.digit_seen)
            begin
                nxt.addr_acc    = {cur.addr_acc[23:0], cur.field_value};
                nxt.field_value = '0;
                nxt.digit_seen  = 1'b0;
                nxt.phase       = cur.phase + 3'd1;
            end
            else
            begin
                nxt.failed = 1'b1;
            end
        end
        else if (ch == icp_pkg::CH_SLASH)
        begin
            if ((cur.phase == icp_pkg::PH_OCT3) && cur.digit_seen)
            begin
                nxt.addr_acc    = {cur.addr_acc[23:0], cur.field_value};
                nxt.field_value = '0;
                nxt.digit_seen  = 1'b0;
                nxt.phase       = icp_pkg::PH_PREFIX;
            end
            else
            begin
                nxt.failed = 1'b1;
            end
        end
        else
        begin
            nxt.failed = 1'b1;
        end
    end

    always_comb
    begin
        res = '0;
        priority if (nxt.failed || !nxt.digit_seen)
        begin
            res = '0;
        end
        else if (nxt.phase == icp_pkg::PH_OCT3)
        begin
            res.valid_res = 1'b1;
            res.address   = {nxt.addr_acc[23:0], nxt.field_value};
        end
        else if (nxt.phase == icp_pkg::PH_PREFIX)
        begin
            res.valid_res  = 1'b1;
            res.address    = nxt.addr_acc;
            res.has_prefix = 1'b1;
            res.prefix_len = nxt.field_value[5:0];
        end
        else
        begin
            res = '0;
        end
    end

    // state clears after every string
    assign nxt_state = last ? icp_pkg::STATE_RESET : nxt;

endmodule

// ----- rtl/icp_out_reg.sv -----
// ============================================================================
// icp_out_reg
// Result register with valid/ready handshake toward the receiver.
// ============================================================================
module icp_out_reg
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  icp_pkg::icp_result_t load_res,
    input  logic                 res_ready,
    output logic                 res_valid,
    output logic                 room,
    output icp_pkg::icp_result_t res
);

    logic                 res_valid_reg;
    icp_pkg::icp_result_t res_reg;

    assign room      = !res_valid_reg || res_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_res;
        end
    end

endmodule

// ----- rtl/ipv4_cidr_text_parser_core.sv -----
// ============================================================================
// ipv4_cidr_text_parser_core
// Streaming parser for IPv4 dotted-quad text with optional CIDR prefix.
// ============================================================================
// Input channel: one character per beat on ch, with last on the final
// character of a string; ch_valid / ch_ready handshake.
// Result channel: one beat per string, carrying valid_res, address,
// has_prefix and prefix_len; res_valid / res_ready handshake. Invalid
// strings report all-zero address, flag and length.
// Throughput: one character per cycle while no stalled result waits in the
// result register; the character step between the parser state registers
// and the result register is combinational. The result of a string is
// registered and appears in the cycle after its last character is accepted.
// A stalled result holds in the result register; ch_ready stays high while
// that register is empty or being drained in the same cycle, so a waiting
// result blocks only further input, never a beat in flight.
// Reset clears the parser state and drops res_valid; no result is pending.
// ============================================================================
`include "ipv4_cidr_text_parser_core_macros.svh"

module ipv4_cidr_text_parser_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        ch_valid,
    output logic        ch_ready,
    input  logic [7:0]  ch,
    input  logic        last,
    output logic        res_valid,
    input  logic        res_ready,
    output logic        valid_res,
    output logic [31:0] address,
    output logic        has_prefix,
    output logic [5:0]  prefix_len
);

    icp_pkg::icp_state_t  state_reg;
    icp_pkg::icp_state_t  state_next;
    icp_pkg::icp_result_t step_res;
    icp_pkg::icp_result_t out_res;
    logic                 room;
    logic                 ch_accept;

    assign ch_ready  = room;
    assign ch_accept = ch_valid && ch_ready;

    icp_step u_step
    (
        .cur       (state_reg),
        .ch        (ch),
        .last      (last),
        .nxt_state (state_next),
        .res       (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= icp_pkg::STATE_RESET;
        end
        else if (ch_accept)
        begin
            state_reg <= state_next;
        end
    end

    icp_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (ch_accept && last),
        .load_res  (step_res),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .room      (room),
        .res       (out_res)
    );

    assign valid_res  = out_res.valid_res;
    assign address    = out_res.address;
    assign has_prefix = out_res.has_prefix;
    assign prefix_len = out_res.prefix_len;

    `ICP_ASSERT_NEXT(a_last_gives_result, ch_accept && last, res_valid, "last beat produced no result")
    `ICP_ASSERT_NEXT(a_last_clears_state, ch_accept && last, state_reg == icp_pkg::STATE_RESET, "state not cleared after string")
    `ICP_ASSERT_NOW(a_invalid_is_zero, res_valid && !valid_res, (address == 32'd0) && !has_prefix && (prefix_len == 6'd0), "invalid result carries nonzero fields")
    `ICP_ASSERT_NOW(a_prefix_range, res_valid && has_prefix, valid_res && (prefix_len <= 6'd32), "prefix result out of range")
    `ICP_ASSERT_NOW(a_phase_range, 1'b1, state_reg.phase <= icp_pkg::PH_PREFIX, "parser phase out of range")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the IPv4 dotted-quad / CIDR text parser core.
// ============================================================================
// Strings go in one character per beat and come out as one result per string.
// A queue of pending characters feeds a bursty driver. A monitor runs a
// character-level parser of its own on every accepted input beat and checks
// each result beat, field by field, against the oldest predicted result.
// The stimulus starts with hand-picked strings: field extremes, leading
// zeros, overflow, empty fields, stray separators, truncation, odd bytes.
// Random strings follow, mostly well-formed with random values, plus
// overflowed, edited and pure noise strings. The result side stalls in
// changing patterns and holds off once for a long stretch. The sender
// pauses twice until no result is outstanding.
// ============================================================================
module tb;

    localparam int N_CHARS     = 1950;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AT     = 800;
    localparam int HOLD_LEN    = 400;

    typedef struct packed {
        logic [7:0] c;
        logic       fin;
        logic       pause;
    } beat_t;

    typedef enum {SK_CLEAN, SK_OVERFLOW, SK_EDITED, SK_NOISE} str_kind_t;
    typedef enum {ED_REPLACE, ED_DROP, ED_INSERT, ED_SEPARATOR, ED_CUT} edit_t;
    typedef enum {RX_OPEN, RX_HALF, RX_SPARSE, RX_TOGGLE} rx_mode_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        ch_valid   = 1'b0;
    logic        ch_ready;
    logic [7:0]  ch         = '0;
    logic        last       = 1'b0;
    logic        res_valid;
    logic        res_ready  = 1'b0;
    logic        valid_res;
    logic [31:0] address;
    logic        has_prefix;
    logic [5:0]  prefix_len;

    beat_t                parse_pend_dummy;
    beat_t                pend_q[$];
    logic [7:0]           txt_q[$];
    icp_pkg::icp_result_t parse_results_q[$];

    int outstanding   = 0;
    int mismatches    = 0;
    int n_chars       = 0;
    int n_results     = 0;
    int n_valid       = 0;
    int n_with_prefix = 0;
    int cycles        = 0;

    // parser state mirrored by the bench
    logic [2:0]  p_phase  = icp_pkg::PH_OCT0;
    logic [7:0]  p_field  = '0;
    logic        p_digit  = 1'b0;
    logic [31:0] p_acc    = '0;
    logic        p_failed = 1'b0;

    ipv4_cidr_text_parser_core i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ch_valid   (ch_valid),
        .ch_ready   (ch_ready),
        .ch         (ch),
        .last       (last),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .valid_res  (valid_res),
        .address    (address),
        .has_prefix (has_prefix),
        .prefix_len (prefix_len)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    task automatic parse_step(input logic [7:0] c, input logic fin);
        logic [11:0] next_val;
        logic [11:0] limit;
        icp_pkg::icp_result_t r;
        if (p_failed || p_phase > icp_pkg::PH_PREFIX)
            p_failed = 1'b1;
        else if (c >= icp_pkg::CH_ZERO && c <= icp_pkg::CH_NINE)
        begin
            limit    = (p_phase == icp_pkg::PH_PREFIX) ? icp_pkg::PREFIX_MAX
                                                       : icp_pkg::OCTET_MAX;
            next_val = 12'(p_field) * 12'd10 + 12'(c - icp_pkg::CH_ZERO);
            if (next_val > limit)
                p_failed = 1'b1;
            else
            begin
                p_field = next_val[7:0];
                p_digit = 1'b1;
            end
        end
        else if (c == icp_pkg::CH_DOT)
        begin
            if (p_phase < icp_pkg::PH_OCT3 && p_digit)
            begin
                p_acc   = {p_acc[23:0], p_field};
                p_field = '0;
                p_digit = 1'b0;
                p_phase = p_phase + 3'd1;
            end
            else
                p_failed = 1'b1;
        end
        else if (c == icp_pkg::CH_SLASH)
        begin
            if (p_phase == icp_pkg::PH_OCT3 && p_digit)
            begin
                p_acc   = {p_acc[23:0], p_field};
                p_field = '0;
                p_digit = 1'b0;
                p_phase = icp_pkg::PH_PREFIX;
            end
            else
                p_failed = 1'b1;
        end
        else
            p_failed = 1'b1;

        if (fin)
        begin
            r = '0;
            if (!p_failed && p_digit)
            begin
                if (p_phase == icp_pkg::PH_OCT3)
                begin
                    r.valid_res = 1'b1;
                    r.address   = {p_acc[23:0], p_field};
                end
                else if (p_phase == icp_pkg::PH_PREFIX)
                begin
                    r.valid_res  = 1'b1;
                    r.address    = p_acc;
                    r.has_prefix = 1'b1;
                    r.prefix_len = p_field[5:0];
                end
            end
            parse_results_q.push_back(r);
            p_phase  = icp_pkg::PH_OCT0;
            p_field  = '0;
            p_digit  = 1'b0;
            p_acc    = '0;
            p_failed = 1'b0;
        end
    endtask

    // driver: bursts of beats with random gaps
    int    burst_left = 0;
    int    gap_left   = 0;
    logic  take;
    beat_t nb;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_valid <= 1'b0;
            ch       <= '0;
            last     <= 1'b0;
        end
        else if (!ch_valid || ch_ready)
        begin
            take = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pend_q.size() > 0 &&
                     !(pend_q[0].pause && (ch_valid || outstanding != 0)))
                take = 1'b1;

            if (take)
            begin
                nb = pend_q.pop_front();
                ch_valid <= 1'b1;
                ch       <= nb.c;
                last     <= nb.fin;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                              : $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            else
                ch_valid <= 1'b0;
        end
    end

    // result side: changing stall patterns, one long hold-off
    rx_mode_t rx_mode   = RX_OPEN;
    int       rx_left   = 0;
    int       rx_cycles = 0;
    int       hold_left = 0;
    logic     rdy;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else
        begin
            rx_cycles++;
            if (rx_cycles == HOLD_AT)
                hold_left = HOLD_LEN;
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = rx_mode_t'($urandom_range(0, 3));
                    rx_left = $urandom_range(32, 256);
                end
                rx_left--;
                case (rx_mode)
                    RX_OPEN:   rdy = 1'b1;
                    RX_HALF:   rdy = 1'($urandom_range(0, 1));
                    RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
                    default:   rdy = rx_cycles[0];
                endcase
            end
            res_ready <= rdy;
        end
    end

    // monitor: results are checked before the same edge's input beat is predicted
    icp_pkg::icp_result_t want;
    icp_pkg::icp_result_t got;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outstanding <= 0;
        else
        begin
            if (res_valid && res_ready)
            begin
                got = {valid_res, address, has_prefix, prefix_len};
                n_results++;
                if (parse_results_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: result beat %0d with none expected: %0b %08h %0b %0d",
                                 n_results, got.valid_res, got.address,
                                 got.has_prefix, got.prefix_len);
                end
                else
                begin
                    want = parse_results_q.pop_front();
                    if (got.valid_res !== want.valid_res || got.address !== want.address ||
                        got.has_prefix !== want.has_prefix ||
                        got.prefix_len !== want.prefix_len)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("tb: string %0d want %0b %08h %0b %0d got %0b %08h %0b %0d",
                                     n_results, want.valid_res, want.address,
                                     want.has_prefix, want.prefix_len, got.valid_res,
                                     got.address, got.has_prefix, got.prefix_len);
                    end
                    if (want.valid_res)
                        n_valid++;
                    if (want.has_prefix)
                        n_with_prefix++;
                end
            end
            if (ch_valid && ch_ready)
            begin
                n_chars++;
                parse_step(ch, last);
            end
            outstanding <= parse_results_q.size();
        end
    end

    task automatic emit_text(input bit pause);
        for (int i = 0; i < txt_q.size(); i++)
            pend_q.push_back('{c: txt_q[i], fin: (i == txt_q.size() - 1),
                               pause: (pause && i == 0)});
        txt_q.delete();
    endtask

    task automatic push_str(input string s);
        txt_q.delete();
        for (int i = 0; i < s.len(); i++)
            txt_q.push_back(s[i]);
        emit_text(1'b0);
    endtask

    task automatic add_dec(input int v, input int zeros);
        string s;
        repeat (zeros)
            txt_q.push_back(icp_pkg::CH_ZERO);
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++)
            txt_q.push_back(s[i]);
    endtask

    task automatic gen_address(input bit pause);
        str_kind_t kind;
        edit_t     ed;
        int        r;
        int        v;
        int        bad;
        int        pos;
        bit        with_pfx;
        txt_q.delete();
        r = $urandom_range(0, 9);
        kind = (r < 6) ? SK_CLEAN : (r == 6) ? SK_OVERFLOW : (r < 9) ? SK_EDITED : SK_NOISE;
        if (kind == SK_NOISE)
        begin
            repeat ($urandom_range(1, 12))
            begin
                case ($urandom_range(0, 3))
                    0:       txt_q.push_back(icp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
                    1:       txt_q.push_back(icp_pkg::CH_DOT);
                    2:       txt_q.push_back(icp_pkg::CH_SLASH);
                    default: txt_q.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
        else
        begin
            with_pfx = 1'($urandom_range(0, 1));
            bad = (kind == SK_OVERFLOW) ? $urandom_range(0, 4) : 5;
            if (bad == 4)
                with_pfx = 1'b1;
            for (int o = 0; o < 4; o++)
            begin
                if (o > 0)
                    txt_q.push_back(icp_pkg::CH_DOT);
                if (o == bad)
                    v = $urandom_range(256, 999);
                else if ($urandom_range(0, 3) == 0)
                    v = $urandom_range(0, 1) ? 255 - $urandom_range(0, 6) : $urandom_range(0, 10);
                else
                    v = $urandom_range(0, 255);
                add_dec(v, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
            end
            if (with_pfx)
            begin
                txt_q.push_back(icp_pkg::CH_SLASH);
                if (bad == 4)
                    v = $urandom_range(33, 99);
                else if ($urandom_range(0, 2) == 0)
                    v = $urandom_range(0, 1) ? 32 : 0;
                else
                    v = $urandom_range(0, 32);
                add_dec(v, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0);
            end
            if (kind == SK_EDITED)
            begin
                ed  = edit_t'($urandom_range(0, 4));
                pos = $urandom_range(0, txt_q.size() - 1);
                case (ed)
                    ED_REPLACE:   txt_q[pos] = 8'($urandom_range(0, 255));
                    ED_DROP:      if (txt_q.size() > 1) txt_q.delete(pos);
                    ED_INSERT:    txt_q.insert(pos, 8'($urandom_range(0, 255)));
                    ED_SEPARATOR: txt_q.insert(pos, $urandom_range(0, 1) ? icp_pkg::CH_DOT
                                                                         : icp_pkg::CH_SLASH);
                    default:
                        while (txt_q.size() > pos + 1)
                            void'(txt_q.pop_back());
                endcase
            end
        end
        emit_text(pause);
    endtask

    int n_gen;

    initial
    begin
        push_str("0.0.0.0");
        push_str("255.255.255.255/32");
        push_str("255.255.255.255");
        push_str("000.01.002.255/032");
        push_str("10.0.0.1/0");
        push_str("256.1.1.1");
        push_str("1.2.3.2550");
        push_str("1.2.3.4/33");
        push_str("1.2.3.4/320");
        push_str("1..2.3");
        push_str(".1.2.3.4");
        push_str("1.2.3.4.5");
        push_str("1.2/3.4");
        push_str("1.2.3.4//5");
        push_str("1.2.3.4/");
        push_str("1.2.3");
        push_str("1.2.3.4/5.6");
        push_str("1.2.3.4x5.6.7.8");
        push_str("192.168.1.1");
        push_str("a.b.c.d");
        push_str("9");
        push_str("/");
        // digit with the top bit set, then NUL and all-ones bytes
        txt_q = '{8'h31, icp_pkg::CH_DOT, 8'h32, icp_pkg::CH_DOT, 8'h33, icp_pkg::CH_DOT,
                  8'hB4};
        emit_text(1'b0);
        txt_q = '{8'h00};
        emit_text(1'b0);
        txt_q = '{8'h37, 8'hFF};
        emit_text(1'b0);

        n_gen = 0;
        while (pend_q.size() < N_CHARS)
        begin
            gen_address(n_gen == 0 || n_gen == 90);
            n_gen++;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pend_q.size() != 0 || ch_valid)
            @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (parse_results_q.size() != 0)
        begin
            $display("tb: %0d results never arrived", parse_results_q.size());
            mismatches += parse_results_q.size();
        end
        $display("tb: %0d characters, %0d strings checked, %0d valid, %0d with prefix",
                 n_chars, n_results, n_valid, n_with_prefix);
        $display("tb: %0d mismatches over %0d cycles, incl. a %0d-cycle result hold-off",
                 mismatches, cycles, HOLD_LEN);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
